[rtl/fifo_session_key_value_cache_core_macros.svh]
// Assertion macros for the cache core RTL.
`ifndef FIFO_SESSION_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define FIFO_SESSION_KEY_VALUE_CACHE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define KVC_ASSERT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("kvc assertion failed");
`define KVC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("kvc assertion failed");
`else
`define KVC_ASSERT(lbl, ck, rn, ante, cons)
`define KVC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

[rtl/kvc_pkg.sv]
`default_nettype none
package kvc_pkg;

    localparam int KVC_ENTRIES     = 64;
    localparam int KVC_KEY_BYTES   = 64;
    localparam int KVC_VALUE_BYTES = 512;
    localparam int KVC_MAX_RESULTS = 64;
    localparam int KVC_LEN_W       = 10;
    localparam int KVC_WORD_W      = 64;

    localparam logic [1:0] KVC_MODE_STORE    = 2'd0;
    localparam logic [1:0] KVC_MODE_RETRIEVE = 2'd1;
    localparam logic [1:0] KVC_MODE_REMOVE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_VRD,
        ST_VOUT,
        ST_RESP
    } kvc_state_t;

    // slot table port control
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } kvc_slot_ctl_t;

endpackage
`default_nettype wire

[rtl/kvc_slot_mem.sv]
`default_nettype none
module kvc_slot_mem
    import kvc_pkg::*;
#(
    parameter int ENTRIES = KVC_ENTRIES,
    parameter int KEY_W   = 512,
    parameter int KLEN_W  = 7,
    parameter int VLEN_W  = 10,
    parameter int SLOT_W  = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kvc_slot_ctl_t       ctl,
    input  wire logic [SLOT_W-1:0]   rd_addr,
    input  wire logic [SLOT_W-1:0]   wr_addr,
    input  wire logic [KEY_W-1:0]    wr_key,
    input  wire logic [KLEN_W-1:0]   wr_klen,
    input  wire logic [VLEN_W-1:0]   wr_vlen,
    output logic      [KEY_W-1:0]    rd_key,
    output logic      [KLEN_W-1:0]   rd_klen,
    output logic      [VLEN_W-1:0]   rd_vlen
);

    localparam int ROW_W = KEY_W + KLEN_W + VLEN_W;

    logic [ROW_W-1:0]   slot_mem [ENTRIES];
    logic [ROW_W-1:0]   rd_row_reg;
    logic [ENTRIES-1:0] vld_reg;
    logic               rd_vld_reg;

    // row storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            slot_mem[wr_addr] <= {wr_key, wr_klen, wr_vlen};
        end
        if (ctl.rd)
        begin
            rd_row_reg <= slot_mem[rd_addr];
        end
    end

    // an invalid slot reads with zero lengths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            else if (ctl.clr)
            begin
                vld_reg[wr_addr] <= 1'b0;
            end
            if (ctl.rd)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_key  = rd_row_reg[ROW_W-1 -: KEY_W];
    assign rd_klen = rd_vld_reg ? rd_row_reg[VLEN_W +: KLEN_W] : '0;
    assign rd_vlen = rd_vld_reg ? rd_row_reg[VLEN_W-1:0] : '0;

endmodule
`default_nettype wire

[rtl/kvc_value_mem.sv]
`default_nettype none
module kvc_value_mem
    import kvc_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire logic [KVC_WORD_W-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output logic      [KVC_WORD_W-1:0] rdata
);

    logic [KVC_WORD_W-1:0] val_mem [DEPTH];
    logic [KVC_WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            val_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= val_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/fifo_session_key_value_cache_core.sv]
// Input items are taken one per cycle while idle; an item without tlast gives no result.
// A closing store item moves the block through EXEC to RESP, which loads the result. Retrieve/remove:
// slot table scanned one slot per cycle through its read port, then RESP or the value readout.
// Retrieved value words leave one at a time (value memory read, then output register).
// Reset clears slot valid bits, write pointer, pending key and output; memories keep contents.
`default_nettype none
module fifo_session_key_value_cache_core
    import kvc_pkg::*;
#(
    parameter int ENTRIES     = KVC_ENTRIES,
    parameter int KEY_BYTES   = KVC_KEY_BYTES,
    parameter int VALUE_BYTES = KVC_VALUE_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // data[63:0], length[73:64], zero pad
    input  wire logic [2:0]  s_tuser,   // mode[1:0], part[2]
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata,   // data_res[63:0], length_res[73:64], zero pad
    output logic      [0:0]  m_tuser,   // status[0]
    output logic             m_tlast    // last_res
);

    `include "fifo_session_key_value_cache_core_macros.svh"

    localparam int KWORDS  = (KEY_BYTES + 7) / 8;
    localparam int VWORDS  = (VALUE_BYTES + 7) / 8;
    localparam int KEY_W   = KWORDS * KVC_WORD_W;
    localparam int KLEN_W  = $clog2(KEY_BYTES + 1);
    localparam int VLEN_W  = $clog2(VALUE_BYTES + 1);
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SCNT_W  = $clog2(ENTRIES + 1);
    localparam int KW_W    = (KWORDS > 1) ? $clog2(KWORDS) : 1;
    localparam int VDEPTH  = ENTRIES * VWORDS;
    localparam int VADDR_W = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int MAXR    = (VWORDS < KVC_MAX_RESULTS) ? VWORDS : KVC_MAX_RESULTS;
    localparam int NW_W    = $clog2(MAXR + 1);

    kvc_state_t state_reg, state_next;

    // pending operation
    logic [KWORDS-1:0][KVC_WORD_W-1:0] pkey_reg;
    logic [KVC_LEN_W-1:0] pklen_reg;
    logic [KVC_LEN_W-1:0] pvlen_reg;
    logic [7:0]           wcnt_reg;
    logic                 rej_reg;
    logic                 inval_reg;
    logic [1:0]           mode_reg;
    logic [SLOT_W-1:0]    wp_reg;

    // scan and readout
    logic [SCNT_W-1:0]    scan_idx_reg;
    logic                 cmp_vld_reg;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic [SLOT_W-1:0]    hit_reg;
    logic [VLEN_W-1:0]    vlen_reg;
    logic [NW_W-1:0]      nw_reg;
    logic [NW_W-1:0]      k_reg;
    logic                 res_st_reg;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 o_st_reg;
    logic [KVC_WORD_W-1:0] o_data_reg;
    logic [KVC_LEN_W-1:0] o_len_reg;
    logic                 o_last_reg;

    // input decode
    logic                  in_acc;
    logic [1:0]            in_mode;
    logic                  in_part;
    logic [KVC_WORD_W-1:0] in_data;
    logic [KVC_LEN_W-1:0]  in_len;
    logic                  key_restart;
    logic                  val_start;
    logic [7:0]            wc_eff;
    logic                  rej_eff;
    logic                  pend_clr;

    // memory side
    kvc_slot_ctl_t         slot_ctl;
    logic [SLOT_W-1:0]     slot_waddr;
    logic [KEY_W-1:0]      rd_key;
    logic [KLEN_W-1:0]     rd_klen;
    logic [VLEN_W-1:0]     rd_vlen;
    logic                  val_we;
    logic                  val_re;
    logic [VADDR_W-1:0]    val_waddr;
    logic [VADDR_W-1:0]    val_raddr;
    logic [KVC_WORD_W-1:0] val_rdata;

    logic [KEY_W-1:0]      kmask;
    logic                  match;
    logic                  hit;
    logic                  miss_done;
    logic [VLEN_W:0]       nw_full;
    logic [NW_W-1:0]       nw_hit;
    logic                  out_free;
    logic                  out_load;
    logic                  last_word;
    logic [VLEN_W:0]       rem;
    logic [KVC_WORD_W-1:0] omask;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_mode  = s_tuser[1:0];
    assign in_part  = s_tuser[2];
    assign in_data  = s_tdata[63:0];
    assign in_len   = s_tdata[73:64];

    // a key word after value words, or on a fresh run, restarts the key
    assign key_restart = !in_part && (inval_reg || (wcnt_reg == 8'd0));
    assign val_start   = in_part && !inval_reg;
    assign wc_eff      = (key_restart || val_start) ? 8'd0 : wcnt_reg;
    assign rej_eff     = key_restart ? ({1'b0, in_len} > (KVC_LEN_W+1)'(KEY_BYTES))
                       : (rej_reg || (val_start &&
                          ({1'b0, in_len} > (KVC_LEN_W+1)'(VALUE_BYTES))));

    assign val_we    = in_acc && in_part && (in_mode == KVC_MODE_STORE) && !rej_eff
                       && (wc_eff < VWORDS);
    assign val_waddr = VADDR_W'(wp_reg) * VADDR_W'(VWORDS) + VADDR_W'(wc_eff);
    assign val_raddr = VADDR_W'(hit_reg) * VADDR_W'(VWORDS) + VADDR_W'(k_reg);

    // key compare: only bytes below the pending length count
    always_comb
    begin
        for (int i = 0; i < KWORDS * 8; i++)
        begin
            kmask[8*i +: 8] = (pklen_reg > KVC_LEN_W'(i)) ? 8'hFF : 8'h00;
        end
    end

    // a compare still in flight after the scan ends must not move the hit slot
    assign match     = (KVC_LEN_W'(rd_klen) == pklen_reg)
                       && (((rd_key ^ pkey_reg) & kmask) == '0);
    assign hit       = cmp_vld_reg && match && (state_reg == ST_SCAN);
    assign miss_done = cmp_vld_reg && !match && (cmp_idx_reg == SLOT_W'(ENTRIES - 1));

    assign nw_full = ((VLEN_W+1)'(rd_vlen) + (VLEN_W+1)'(7)) >> 3;
    assign nw_hit  = (nw_full > MAXR) ? NW_W'(MAXR) : NW_W'(nw_full);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_word = ((k_reg + 1'b1) == nw_reg);

    // zero value bytes past the stored length
    assign rem = (VLEN_W+1)'(vlen_reg) - ((VLEN_W+1)'(k_reg) << 3);
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            omask[8*i +: 8] = (rem > (VLEN_W+1)'(i)) ? 8'hFF : 8'h00;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((mode_reg == KVC_MODE_RETRIEVE) || (mode_reg == KVC_MODE_REMOVE))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if ((mode_reg == KVC_MODE_RETRIEVE) && (nw_hit != '0))
                    begin
                        state_next = ST_VRD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
                else if (miss_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_VRD:
            begin
                state_next = ST_VOUT;
            end
            ST_VOUT:
            begin
                if (out_free)
                begin
                    state_next = last_word ? ST_IDLE : ST_VRD;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        slot_ctl     = '0;
        slot_waddr   = hit_reg;
        val_re       = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_EXEC:
            begin
                slot_ctl.wr = (mode_reg == KVC_MODE_STORE) && !rej_reg;
                slot_waddr  = wp_reg;
            end
            ST_SCAN:
            begin
                slot_ctl.rd  = (scan_idx_reg < ENTRIES);
                slot_ctl.clr = hit && (mode_reg == KVC_MODE_REMOVE);
                slot_waddr   = cmp_idx_reg;
            end
            ST_VRD:
            begin
                val_re = 1'b1;
            end
            ST_VOUT, ST_RESP:
            begin
                out_load = out_free;
            end
            default:
            begin
                slot_ctl = '0;
            end
        endcase
    end

    assign pend_clr      = (state_reg != ST_IDLE) && (state_next == ST_IDLE);
    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // pending key and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkey_reg  <= '0;
            pklen_reg <= '0;
            pvlen_reg <= '0;
            wcnt_reg  <= '0;
            rej_reg   <= 1'b0;
            inval_reg <= 1'b0;
            mode_reg  <= KVC_MODE_STORE;
        end
        else if (pend_clr)
        begin
            pkey_reg  <= '0;
            pklen_reg <= '0;
            pvlen_reg <= '0;
            wcnt_reg  <= '0;
            rej_reg   <= 1'b0;
            inval_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            if (key_restart)
            begin
                pkey_reg  <= '0;
                pklen_reg <= in_len;
                pvlen_reg <= '0;
                inval_reg <= 1'b0;
            end
            if (val_start)
            begin
                inval_reg <= 1'b1;
                pvlen_reg <= in_len;
            end
            if (!in_part && (wc_eff < KWORDS))
            begin
                pkey_reg[wc_eff[KW_W-1:0]] <= in_data;
            end
            rej_reg  <= rej_eff;
            wcnt_reg <= (wc_eff == 8'd255) ? 8'd255 : wc_eff + 8'd1;
            if (s_tlast)
            begin
                mode_reg <= in_mode;
            end
        end
    end

    // write pointer, scan and readout control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            k_reg        <= '0;
            nw_reg       <= '0;
            res_st_reg   <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= slot_ctl.rd;
            if (slot_ctl.wr)
            begin
                wp_reg <= (wp_reg == SLOT_W'(ENTRIES - 1)) ? '0 : wp_reg + 1'b1;
            end
            case (state_reg)
                ST_EXEC:
                begin
                    scan_idx_reg <= '0;
                    res_st_reg   <= (mode_reg == KVC_MODE_STORE) ? rej_reg : 1'b1;
                end
                ST_SCAN:
                begin
                    if (slot_ctl.rd)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        res_st_reg <= 1'b0;
                        nw_reg     <= nw_hit;
                        k_reg      <= '0;
                    end
                    else if (miss_done)
                    begin
                        res_st_reg <= 1'b1;
                    end
                end
                ST_VOUT:
                begin
                    if (out_free)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    scan_idx_reg <= scan_idx_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (slot_ctl.rd)
        begin
            cmp_idx_reg <= scan_idx_reg[SLOT_W-1:0];
        end
        if (hit)
        begin
            hit_reg  <= cmp_idx_reg;
            vlen_reg <= rd_vlen;
        end
        if (out_load)
        begin
            if (state_reg == ST_VOUT)
            begin
                o_st_reg   <= 1'b0;
                o_data_reg <= val_rdata & omask;
                o_len_reg  <= KVC_LEN_W'(vlen_reg);
                o_last_reg <= last_word;
            end
            else
            begin
                o_st_reg   <= res_st_reg;
                o_data_reg <= '0;
                o_len_reg  <= '0;
                o_last_reg <= 1'b1;
            end
        end
    end

    kvc_slot_mem #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .KLEN_W  (KLEN_W),
        .VLEN_W  (VLEN_W),
        .SLOT_W  (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (slot_ctl),
        .rd_addr (scan_idx_reg[SLOT_W-1:0]),
        .wr_addr (slot_waddr),
        .wr_key  (pkey_reg),
        .wr_klen (KLEN_W'(pklen_reg)),
        .wr_vlen (VLEN_W'(pvlen_reg)),
        .rd_key  (rd_key),
        .rd_klen (rd_klen),
        .rd_vlen (rd_vlen)
    );

    kvc_value_mem #(
        .DEPTH  (VDEPTH),
        .ADDR_W (VADDR_W)
    ) u_value_mem (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (in_data),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, o_len_reg, o_data_reg};
    assign m_tuser  = o_st_reg;
    assign m_tlast  = o_last_reg;

    `KVC_ASSERT(a_wp_range, clk, rst_n, 1'b1, wp_reg <= SLOT_W'(ENTRIES - 1))
    `KVC_ASSERT(a_word_in_run, clk, rst_n, state_reg == ST_VOUT, k_reg < nw_reg)
    `KVC_ASSERT(a_no_value_write_in_scan, clk, rst_n, state_reg == ST_SCAN, !val_we)
    `KVC_ASSERT_NEXT(a_store_advances, clk, rst_n, slot_ctl.wr && (ENTRIES > 1),
        wp_reg != $past(wp_reg))

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import kvc_pkg::*;

    // mode 3 has no operation behind it; the block must answer "not found"
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int KWORDS    = KVC_KEY_BYTES / 8;
    localparam int VWORDS    = KVC_VALUE_BYTES / 8;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;    // data[63:0], length[73:64], zero pad
    logic [2:0]  s_tuser;    // mode[1:0], part[2]
    logic        s_tlast;    // last
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;    // data_res[63:0], length_res[73:64], zero pad
    logic [0:0]  m_tuser;    // status[0]
    logic        m_tlast;    // last_res

    fifo_session_key_value_cache_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // one result item of the cache
    typedef struct {
        bit          status;
        logic [63:0] data;
        logic [9:0]  len;
        bit          last;
    } cache_res_t;

    cache_res_t answer_q[$];

    // shadow copy of the cache contents
    logic [63:0] key_mem [KVC_ENTRIES*KWORDS];
    logic [63:0] val_mem [KVC_ENTRIES*VWORDS];
    int          key_len_tab [KVC_ENTRIES];
    int          val_len_tab [KVC_ENTRIES];
    int          wr_slot;
    logic [63:0] acc_key [KWORDS];
    int          acc_key_len;
    int          acc_val_len;
    int          word_cnt;
    bit          rejected;
    bit          in_value;

    int errors;
    int items_sent;
    int results_seen;
    int n_store, n_retrieve, n_remove, n_noise;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit rcv_hold;
    int quiet_cycles;

    always #2 clk = ~clk;

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
    end

    function automatic logic [63:0] byte_mask(int n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic void clear_acc();
        for (int i = 0; i < KWORDS; i++)
            acc_key[i] = '0;
        acc_key_len = 0;
        acc_val_len = 0;
        word_cnt    = 0;
        rejected    = 1'b0;
        in_value    = 1'b0;
    endfunction

    // lowest slot whose key has the same length and bytes, or -1
    function automatic int lookup_slot();
        bit hit;
        for (int s = 0; s < KVC_ENTRIES; s++)
        begin
            hit = (key_len_tab[s] == acc_key_len);
            for (int w = 0; w < KWORDS && 8 * w < acc_key_len && hit; w++)
                if (((key_mem[s*KWORDS+w] ^ acc_key[w]) & byte_mask(acc_key_len - 8*w)) != 0)
                    hit = 1'b0;
            if (hit)
                return s;
        end
        return -1;
    endfunction

    function automatic void push_answer(bit st, logic [63:0] d, int len, bit lst);
        cache_res_t r;
        r.status = st;
        r.data   = d;
        r.len    = len[9:0];
        r.last   = lst;
        answer_q.push_back(r);
    endfunction

    // advance the shadow cache by one accepted item and queue what it answers
    function automatic void cache_predict(logic [1:0] mode, bit part, logic [63:0] data,
                                          int len, bit last);
        int f;
        int nw;
        int vl;
        if (!part)
        begin
            if (in_value || word_cnt == 0)
            begin
                clear_acc();
                acc_key_len = len;
                if (len > KVC_KEY_BYTES)
                    rejected = 1'b1;
            end
            if (word_cnt < KWORDS)
                acc_key[word_cnt] = data;
        end
        else
        begin
            if (!in_value)
            begin
                in_value    = 1'b1;
                word_cnt    = 0;
                acc_val_len = len;
                if (len > KVC_VALUE_BYTES)
                    rejected = 1'b1;
            end
            if (mode == KVC_MODE_STORE && !rejected && word_cnt < VWORDS)
                val_mem[wr_slot*VWORDS+word_cnt] = data;
        end
        if (word_cnt < 255)
            word_cnt++;
        if (!last)
            return;

        case (mode)
            KVC_MODE_STORE:
            begin
                if (rejected)
                    push_answer(1, 0, 0, 1);
                else
                begin
                    for (int w = 0; w < KWORDS; w++)
                        key_mem[wr_slot*KWORDS+w] = acc_key[w];
                    key_len_tab[wr_slot] = acc_key_len;
                    val_len_tab[wr_slot] = acc_val_len;
                    wr_slot = (wr_slot + 1) % KVC_ENTRIES;
                    push_answer(0, 0, 0, 1);
                end
            end
            KVC_MODE_RETRIEVE:
            begin
                f = lookup_slot();
                if (f < 0)
                    push_answer(1, 0, 0, 1);
                else
                begin
                    vl = val_len_tab[f];
                    nw = (vl + 7) / 8;
                    if (nw > KVC_MAX_RESULTS)
                        nw = KVC_MAX_RESULTS;
                    if (nw == 0)
                        push_answer(0, 0, 0, 1);
                    for (int k = 0; k < nw; k++)
                        push_answer(0, val_mem[f*VWORDS+k] & byte_mask(vl - 8*k), vl,
                                    k + 1 == nw);
                end
            end
            KVC_MODE_REMOVE:
            begin
                f = lookup_slot();
                if (f < 0)
                    push_answer(1, 0, 0, 1);
                else
                begin
                    key_len_tab[f] = 0;
                    val_len_tab[f] = 0;
                    push_answer(0, 0, 0, 1);
                end
            end
            default:
                push_answer(1, 0, 0, 1);
        endcase
        clear_acc();
    endfunction

    // offer one item until the block takes it, idling at random in between
    task automatic send_item(logic [1:0] mode, bit part, logic [63:0] data, int len, bit last);
        bit done;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < snd_idle_pct)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, len[9:0], data};
                s_tuser  <= {part, mode};
                s_tlast  <= last;
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                cache_predict(mode, part, data, len, last);
                done = 1'b1;
            end
        end
        items_sent++;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // receiver: stall at random, or hold off entirely during the pressure stretch
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        cache_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (answer_q.size() == 0)
                report_mismatch("unexpected result, data", m_tdata[63:0], 0);
            else
            begin
                e = answer_q.pop_front();
                if (m_tuser[0] !== e.status)
                    report_mismatch("status", m_tuser[0], e.status);
                if (m_tdata[63:0] !== e.data)
                    report_mismatch("data", m_tdata[63:0], e.data);
                if (m_tdata[73:64] !== e.len)
                    report_mismatch("length", m_tdata[73:64], e.len);
                if (m_tlast !== e.last)
                    report_mismatch("last", m_tlast, e.last);
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // pressure: hold the output off for a long stretch once 230 items have been sent
    initial
    begin
        rcv_hold = 1'b0;
        wait (items_sent >= 230);
        @(negedge clk);
        rcv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        @(negedge clk);
        rcv_hold = 1'b0;
    end

    // directed rows; chk marks rows whose single answer is typed in here
    typedef struct {
        logic [1:0]  mode;
        bit          part;
        logic [63:0] data;
        int          len;
        bit          last;
        bit          chk;
        bit          st;
        logic [63:0] dres;
        int          lres;
    } row_t;

    localparam int NROWS = 20;
    row_t rows [NROWS];

    initial
    begin
        rows = '{
            // empty key matches the cleared slot 0: found, length 0
            '{KVC_MODE_RETRIEVE, 0, 64'h0, 0, 1, 1, 0, 64'h0, 0},
            // store 8-byte all-ones key with an all-ones 8-byte value
            '{KVC_MODE_STORE, 0, '1, 8, 0, 0, 0, 0, 0},
            '{KVC_MODE_STORE, 1, '1, 8, 1, 1, 0, 64'h0, 0},
            '{KVC_MODE_RETRIEVE, 0, '1, 8, 1, 1, 0, '1, 8},
            '{KVC_MODE_REMOVE, 0, '1, 8, 1, 1, 0, 64'h0, 0},
            '{KVC_MODE_RETRIEVE, 0, '1, 8, 1, 1, 1, 64'h0, 0},
            // over-long key on store, then over-long value
            '{KVC_MODE_STORE, 0, 64'h1234, 65, 1, 1, 1, 64'h0, 0},
            '{KVC_MODE_STORE, 0, 64'h55, 3, 0, 0, 0, 0, 0},
            '{KVC_MODE_STORE, 1, 64'h77, 1023, 1, 1, 1, 64'h0, 0},
            // over-long key on lookups, and the unused mode
            '{KVC_MODE_RETRIEVE, 0, 64'h0, 1023, 1, 1, 1, 64'h0, 0},
            '{KVC_MODE_REMOVE, 0, 64'h0, 65, 1, 1, 1, 64'h0, 0},
            '{MODE_NONE, 1, '1, 1023, 1, 1, 1, 64'h0, 0},
            // 64-byte key with missing words, 20-byte value, extra value word
            '{KVC_MODE_STORE, 0, 64'hA5A5_0F0F_3C3C_9999, 64, 0, 0, 0, 0, 0},
            '{KVC_MODE_STORE, 1, 64'h0123_4567_89AB_CDEF, 20, 0, 0, 0, 0, 0},
            '{KVC_MODE_STORE, 1, 64'hFEDC_BA98_7654_3210, 20, 0, 0, 0, 0, 0},
            '{KVC_MODE_STORE, 1, '1, 20, 0, 0, 0, 0, 0},
            '{KVC_MODE_STORE, 1, '1, 20, 1, 0, 0, 0, 0},
            // retrieve with a trailing value word, which is ignored
            '{KVC_MODE_RETRIEVE, 0, 64'hA5A5_0F0F_3C3C_9999, 64, 0, 0, 0, 0, 0},
            '{KVC_MODE_RETRIEVE, 1, 64'h0, 0, 1, 0, 0, 0, 0},
            // zero key of 5 bytes, nothing stored under it yet
            '{KVC_MODE_REMOVE, 0, 64'h0, 5, 1, 1, 1, 64'h0, 0}
        };
    end

    // one well-formed operation with random content, sometimes broken up
    logic [511:0] key_pool [$];
    int           key_pool_len [$];

    task automatic run_operation();
        logic [511:0] kw;
        int           kl;
        int           nk;
        int           vl;
        int           nv;
        int           pick;
        int           r;
        logic [1:0]   mode;
        bit           extra;
        if (key_pool.size() != 0 && $urandom_range(0, 1))
        begin
            pick = $urandom_range(0, key_pool.size() - 1);
            kw   = key_pool[pick];
            kl   = key_pool_len[pick];
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                kw[32*i +: 32] = $urandom;
            kl = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(0, 24);
        end
        r    = $urandom_range(0, 99);
        mode = (r < 45) ? KVC_MODE_STORE : (r < 80) ? KVC_MODE_RETRIEVE : KVC_MODE_REMOVE;
        nk   = (kl == 0) ? 1 : (kl + 7) / 8;
        extra = ($urandom_range(0, 9) == 0);

        if (mode == KVC_MODE_STORE)
        begin
            n_store++;
            // broken start: a junk key and value, dropped by the real key
            if (extra)
            begin
                send_item(mode, 0, {$urandom, $urandom}, $urandom_range(0, 64), 0);
                send_item(mode, 1, {$urandom, $urandom}, 8, 0);
            end
            for (int i = 0; i < nk; i++)
                send_item(mode, 0, kw[64*i +: 64], kl, 0);
            vl = ($urandom_range(0, 19) == 0) ? KVC_VALUE_BYTES : $urandom_range(0, 40);
            nv = (vl == 0) ? 1 : (vl + 7) / 8;
            if (nv < VWORDS && $urandom_range(0, 9) == 0)
                nv++;
            for (int i = 0; i < nv; i++)
                send_item(mode, 1, {$urandom, $urandom}, vl, i == nv - 1);
            if (key_pool.size() < 16)
            begin
                key_pool.push_back(kw);
                key_pool_len.push_back(kl);
            end
            else
            begin
                pick = $urandom_range(0, 15);
                key_pool[pick]     = kw;
                key_pool_len[pick] = kl;
            end
        end
        else
        begin
            if (mode == KVC_MODE_RETRIEVE)
                n_retrieve++;
            else
                n_remove++;
            // bytes past the key length are random; the compare masks them
            for (int i = 0; i < nk; i++)
                send_item(mode, 0, kw[64*i +: 64], kl, (i == nk - 1) && !extra);
            if (extra)
                send_item(mode, 1, {$urandom, $urandom}, $urandom_range(0, 1023), 1);
        end
    endtask

    // single closing item with random fields; value words stay fully covered
    task automatic run_noise();
        bit part;
        int len;
        part = 1'($urandom_range(0, 1));
        if (!part)
            len = $urandom_range(0, 1023);
        else
            len = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(513, 1023);
        n_noise++;
        send_item(2'($urandom_range(0, 3)), part, {$urandom, $urandom}, len, 1);
    endtask

    initial
    begin
        cache_res_t e;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        n_store = 0;
        n_retrieve = 0;
        n_remove = 0;
        n_noise = 0;
        quiet_cycles = 0;
        snd_idle_pct = 10;
        rcv_idle_pct = 45;
        for (int s = 0; s < KVC_ENTRIES; s++)
        begin
            key_len_tab[s] = 0;
            val_len_tab[s] = 0;
        end
        wr_slot = 0;
        clear_acc();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: typed rows overwrite the single predicted answer
        for (int i = 0; i < NROWS; i++)
        begin
            send_item(rows[i].mode, rows[i].part, rows[i].data, rows[i].len, rows[i].last);
            if (rows[i].chk)
            begin
                e = answer_q.pop_back();
                push_answer(rows[i].st, rows[i].dres, rows[i].lres, 1);
            end
        end

        // random part in three idling phases
        while (items_sent < 300)
        begin
            if (items_sent >= 120)
            begin
                snd_idle_pct = 45;
                rcv_idle_pct = 10;
            end
            if (items_sent >= 220)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < 80)
                run_operation();
            else
                run_noise();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d items: %0d stores, %0d retrieves, %0d removes, %0d stray items",
                 items_sent, n_store, n_retrieve, n_remove, n_noise);
        $display("checked %0d results, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
